// ----- hw/rtl/rpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpfp_pkg
// Shared widths, types and codes for the four-point radon partition block.
// ----------------------------------------------------------------------------
package rpfp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;

   // queue between front and back, depth must be a power of two
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] HULL_TWO   = 3'd2;
   localparam logic [2:0] HULL_THREE = 3'd3;
   localparam logic [2:0] HULL_FOUR  = 3'd4;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [1:0]             pidx_type;

   typedef struct packed {
      coord_type [3:0] x;
      coord_type [3:0] y;
   } point_set_type;

   typedef struct packed {
      point_set_type pts;
      pidx_type      pivot;
   } front_item_type;

endpackage

// ----- hw/rtl/rpfp_front.sv -----
// ----------------------------------------------------------------------------
// rpfp_front
// Input register: takes a point set and picks the pivot (lowest y, then x).
// ----------------------------------------------------------------------------
module rpfp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rpfp_pkg::point_set_type  req_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rpfp_pkg::front_item_type out_item
);

   logic                     valid_ff;
   logic                     valid_in;
   rpfp_pkg::front_item_type item_ff;
   rpfp_pkg::pidx_type       pivot_in;
   logic                     accept;

   always_comb begin
      pivot_in = '0;
      for (int i = 1; i < 4; i++) begin
         if (($signed(req_item.y[i]) < $signed(req_item.y[pivot_in])) ||
             ((req_item.y[i] == req_item.y[pivot_in]) &&
              ($signed(req_item.x[i]) < $signed(req_item.x[pivot_in])))) begin
            pivot_in = rpfp_pkg::pidx_type'(i);
         end
      end
   end

   assign req_ready = !valid_ff || out_ready;
   assign accept    = req_valid && req_ready;
   assign valid_in  = accept || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.pts   <= req_item;
         item_ff.pivot <= pivot_in;
      end
   end

endmodule

// ----- hw/rtl/rpfp_queue.sv -----
// ----------------------------------------------------------------------------
// rpfp_queue
// Small fifo between the front register and the geometry pipeline.
// ----------------------------------------------------------------------------
module rpfp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  rpfp_pkg::front_item_type push_item,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output rpfp_pkg::front_item_type pop_item
);

   localparam logic [rpfp_pkg::QUEUE_CNT_WIDTH-1:0] QueueFull =
      rpfp_pkg::QUEUE_CNT_WIDTH'(rpfp_pkg::QUEUE_DEPTH);

   rpfp_pkg::front_item_type                   entry_ff [rpfp_pkg::QUEUE_DEPTH];
   logic [rpfp_pkg::QUEUE_PTR_WIDTH-1:0]       wr_ptr_ff;
   logic [rpfp_pkg::QUEUE_PTR_WIDTH-1:0]       rd_ptr_ff;
   logic [rpfp_pkg::QUEUE_CNT_WIDTH-1:0]       count_ff;
   logic [rpfp_pkg::QUEUE_CNT_WIDTH-1:0]       count_in;
   logic                                       push;
   logic                                       pop;

   assign push_ready = (count_ff != QueueFull);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rpfp_pkg::QUEUE_CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rpfp_pkg::QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + rpfp_pkg::QUEUE_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + rpfp_pkg::QUEUE_PTR_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/rpfp_back.sv -----
// ----------------------------------------------------------------------------
// rpfp_back
// Geometry pipeline: triple orientations, polar sort, hull scan, partition.
// ----------------------------------------------------------------------------
module rpfp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rpfp_pkg::front_item_type in_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [3:0]               rsp_first_set_mask,
   output logic [2:0]               rsp_hull_count
);

   typedef logic [rpfp_pkg::DIFF_WIDTH-1:0]  diff_type;
   typedef logic [rpfp_pkg::PROD_WIDTH-1:0]  prod_type;
   typedef logic [rpfp_pkg::CROSS_WIDTH-1:0] cross_type;
   typedef logic [3:0][3:0]                  order_type;

   typedef struct packed {
      diff_type ux;
      diff_type uy;
      diff_type vx;
      diff_type vy;
   } tri_diff_type;

   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

   // vertex in ascending slot order of the triple that leaves out point k
   function automatic rpfp_pkg::pidx_type tri_vertex(input rpfp_pkg::pidx_type k,
                                                     input rpfp_pkg::pidx_type slot);
      return (slot >= k) ? slot + 2'd1 : slot;
   endfunction

   function automatic diff_type widen(input rpfp_pkg::coord_type v);
      return {v[rpfp_pkg::COORD_WIDTH-1], v};
   endfunction

   // orientation of any ordered triple from the four sorted-triple signs
   function automatic sign_type orient_sign(input logic [3:0] pos, input logic [3:0] neg,
                                            input rpfp_pkg::pidx_type a,
                                            input rpfp_pkg::pidx_type b,
                                            input rpfp_pkg::pidx_type c);
      rpfp_pkg::pidx_type m;
      logic               odd;
      sign_type           s;
      m     = a ^ b ^ c;
      odd   = (a > b) ^ (a > c) ^ (b > c);
      s.pos = odd ? neg[m] : pos[m];
      s.neg = odd ? pos[m] : neg[m];
      return s;
   endfunction

   // polar order about the pivot; collinear points share one ray, so the
   // nearer one is the lexicographically smaller (y, x)
   function automatic logic polar_ahead(input logic [3:0] pos, input logic [3:0] neg,
                                        input order_type lt, input rpfp_pkg::pidx_type piv,
                                        input rpfp_pkg::pidx_type a,
                                        input rpfp_pkg::pidx_type b);
      sign_type s;
      s = orient_sign(pos, neg, piv, a, b);
      if (s.pos) begin
         return 1'b1;
      end else if (s.neg) begin
         return 1'b0;
      end
      return lt[a][b] || (!lt[b][a] && (a < b));
   endfunction

   function automatic logic [3:0] bit_of(input rpfp_pkg::pidx_type i);
      return 4'b0001 << i;
   endfunction

   logic adv;

   // stage 1: differences and point order
   logic                   s1_valid_ff;
   tri_diff_type [3:0]     s1_diff_ff;
   tri_diff_type [3:0]     s1_diff_in;
   order_type              s1_lt_ff;
   order_type              s1_lt_in;
   rpfp_pkg::pidx_type     s1_pivot_ff;

   // stage 2: products
   logic                   s2_valid_ff;
   prod_type [3:0]         s2_p1_ff;
   prod_type [3:0]         s2_p2_ff;
   prod_type [3:0]         s2_p1_in;
   prod_type [3:0]         s2_p2_in;
   order_type              s2_lt_ff;
   rpfp_pkg::pidx_type     s2_pivot_ff;

   // stage 3: orientation signs
   logic                   s3_valid_ff;
   logic [3:0]             s3_pos_ff;
   logic [3:0]             s3_neg_ff;
   logic [3:0]             s3_pos_in;
   logic [3:0]             s3_neg_in;
   order_type              s3_lt_ff;
   rpfp_pkg::pidx_type     s3_pivot_ff;

   // output register
   logic                   out_valid_ff;
   logic [3:0]             out_mask_ff;
   logic [3:0]             out_mask_in;
   logic [2:0]             out_count_ff;
   logic [2:0]             out_count_in;

   assign adv      = !out_valid_ff || rsp_ready;
   assign in_ready = adv;

   always_comb begin
      rpfp_pkg::pidx_type a;
      rpfp_pkg::pidx_type b;
      rpfp_pkg::pidx_type c;
      for (int k = 0; k < 4; k++) begin
         a = tri_vertex(rpfp_pkg::pidx_type'(k), 2'd0);
         b = tri_vertex(rpfp_pkg::pidx_type'(k), 2'd1);
         c = tri_vertex(rpfp_pkg::pidx_type'(k), 2'd2);
         s1_diff_in[k].ux = widen(in_item.pts.x[b]) - widen(in_item.pts.x[a]);
         s1_diff_in[k].uy = widen(in_item.pts.y[b]) - widen(in_item.pts.y[a]);
         s1_diff_in[k].vx = widen(in_item.pts.x[c]) - widen(in_item.pts.x[a]);
         s1_diff_in[k].vy = widen(in_item.pts.y[c]) - widen(in_item.pts.y[a]);
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_lt_in[i][j] =
               ($signed(in_item.pts.y[i]) < $signed(in_item.pts.y[j])) ||
               ((in_item.pts.y[i] == in_item.pts.y[j]) &&
                ($signed(in_item.pts.x[i]) < $signed(in_item.pts.x[j])));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s2_p1_in[k] = $signed(s1_diff_ff[k].ux) * $signed(s1_diff_ff[k].vy);
         s2_p2_in[k] = $signed(s1_diff_ff[k].uy) * $signed(s1_diff_ff[k].vx);
      end
   end

   always_comb begin
      cross_type cross_diff;
      for (int k = 0; k < 4; k++) begin
         cross_diff = {s2_p1_ff[k][rpfp_pkg::PROD_WIDTH-1], s2_p1_ff[k]} -
                      {s2_p2_ff[k][rpfp_pkg::PROD_WIDTH-1], s2_p2_ff[k]};
         s3_neg_in[k] = cross_diff[rpfp_pkg::CROSS_WIDTH-1];
         s3_pos_in[k] = !cross_diff[rpfp_pkg::CROSS_WIDTH-1] && (cross_diff != '0);
      end
   end

   // polar sort by rank, then the graham scan unrolled over its few outcomes
   always_comb begin
      logic [2:0][1:0]    ord;
      logic [1:0]         rank;
      rpfp_pkg::pidx_type piv;
      rpfp_pkg::pidx_type o0;
      rpfp_pkg::pidx_type o1;
      rpfp_pkg::pidx_type o2;
      ord = '0;
      piv = s3_pivot_ff;
      for (int i = 0; i < 4; i++) begin
         rank = '0;
         for (int j = 0; j < 4; j++) begin
            if ((j != i) && (rpfp_pkg::pidx_type'(j) != piv) &&
                polar_ahead(s3_pos_ff, s3_neg_ff, s3_lt_ff, piv,
                            rpfp_pkg::pidx_type'(j), rpfp_pkg::pidx_type'(i))) begin
               rank = rank + 2'd1;
            end
         end
         if (rpfp_pkg::pidx_type'(i) != piv) begin
            ord[rank] = rpfp_pkg::pidx_type'(i);
         end
      end
      o0 = ord[0];
      o1 = ord[1];
      o2 = ord[2];
      if (orient_sign(s3_pos_ff, s3_neg_ff, piv, o0, o1).pos) begin
         if (orient_sign(s3_pos_ff, s3_neg_ff, o0, o1, o2).pos) begin
            out_count_in = rpfp_pkg::HULL_FOUR;
            out_mask_in  = bit_of(o0) | bit_of(o2);
         end else if (orient_sign(s3_pos_ff, s3_neg_ff, piv, o0, o2).pos) begin
            out_count_in = rpfp_pkg::HULL_THREE;
            out_mask_in  = bit_of(piv) | bit_of(o0) | bit_of(o2);
         end else begin
            out_count_in = rpfp_pkg::HULL_TWO;
            out_mask_in  = bit_of(piv) | bit_of(o2);
         end
      end else begin
         if (orient_sign(s3_pos_ff, s3_neg_ff, piv, o1, o2).pos) begin
            out_count_in = rpfp_pkg::HULL_THREE;
            out_mask_in  = bit_of(piv) | bit_of(o1) | bit_of(o2);
         end else begin
            out_count_in = rpfp_pkg::HULL_TWO;
            out_mask_in  = bit_of(piv) | bit_of(o2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_diff_ff   <= s1_diff_in;
         s1_lt_ff     <= s1_lt_in;
         s1_pivot_ff  <= in_item.pivot;
         s2_p1_ff     <= s2_p1_in;
         s2_p2_ff     <= s2_p2_in;
         s2_lt_ff     <= s1_lt_ff;
         s2_pivot_ff  <= s1_pivot_ff;
         s3_pos_ff    <= s3_pos_in;
         s3_neg_ff    <= s3_neg_in;
         s3_lt_ff     <= s2_lt_ff;
         s3_pivot_ff  <= s2_pivot_ff;
         out_mask_ff  <= out_mask_in;
         out_count_ff <= out_count_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_first_set_mask = out_mask_ff;
   assign rsp_hull_count     = out_count_ff;

endmodule

// ----- hw/rtl/radon_partition_four_points_top.sv -----
// ----------------------------------------------------------------------------
// radon_partition_four_points_top
// From an accepted request to rsp_valid the path runs through the front register
// (loaded at the accepting edge), the queue, three pipeline stages and the output register.
// Throughput: one transaction per cycle; rsp_ready low stalls the pipeline.
// Reset clears all valid flags and queue pointers; payload is not reset.
// ----------------------------------------------------------------------------
module radon_partition_four_points_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point0_x,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point0_y,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point1_x,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point1_y,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point2_x,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point2_y,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point3_x,
   input  logic [rpfp_pkg::COORD_WIDTH-1:0]    req_point3_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [3:0]                          rsp_first_set_mask,
   output logic [2:0]                          rsp_hull_count
);

   rpfp_pkg::point_set_type  req_item;
   logic                     front_valid;
   logic                     front_ready;
   rpfp_pkg::front_item_type front_item;
   logic                     queue_valid;
   logic                     queue_ready;
   rpfp_pkg::front_item_type queue_item;

   assign req_item.x[0] = req_point0_x;
   assign req_item.y[0] = req_point0_y;
   assign req_item.x[1] = req_point1_x;
   assign req_item.y[1] = req_point1_y;
   assign req_item.x[2] = req_point2_x;
   assign req_item.y[2] = req_point2_y;
   assign req_item.x[3] = req_point3_x;
   assign req_item.y[3] = req_point3_y;

   rpfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   rpfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   rpfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (queue_valid),
      .in_ready           (queue_ready),
      .in_item            (queue_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_set_mask (rsp_first_set_mask),
      .rsp_hull_count     (rsp_hull_count)
   );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radon_partition_four_points_top. Each point set is
// driven on the request channel, and its expected partition mask and hull
// size are worked out at acceptance from a local convex hull computation.
// Responses are checked in order against that queue. Directed shapes come
// first, then random mixes of general, collinear, coincident and extreme
// sets under random gaps and backpressure on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [3:0] mask;
      logic [2:0] hull;
   } partition_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   rpfp_pkg::coord_type   req_point0_x, req_point0_y, req_point1_x, req_point1_y;
   rpfp_pkg::coord_type   req_point2_x, req_point2_y, req_point3_x, req_point3_y;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [3:0]            rsp_first_set_mask;
   logic [2:0]            rsp_hull_count;

   partition_type   expected_partitions [$];
   int              failures;
   int              cycle_count;
   int              hold_off_left;
   bit              req_idle_on;
   bit              rsp_idle_on;

   radon_partition_four_points_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_point0_x       (req_point0_x),
      .req_point0_y       (req_point0_y),
      .req_point1_x       (req_point1_x),
      .req_point1_y       (req_point1_y),
      .req_point2_x       (req_point2_x),
      .req_point2_y       (req_point2_y),
      .req_point3_x       (req_point3_x),
      .req_point3_y       (req_point3_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_set_mask (rsp_first_set_mask),
      .rsp_hull_count     (rsp_hull_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint coord_x(rpfp_pkg::point_set_type p, int k);
      return longint'($signed(p.x[k]));
   endfunction

   function automatic longint coord_y(rpfp_pkg::point_set_type p, int k);
      return longint'($signed(p.y[k]));
   endfunction

   // cross product of (b - a) and (c - a), positive for a left turn
   function automatic longint turn(rpfp_pkg::point_set_type p, int a, int b, int c);
      longint ux, uy, vx, vy;
      ux = coord_x(p, b) - coord_x(p, a);
      uy = coord_y(p, b) - coord_y(p, a);
      vx = coord_x(p, c) - coord_x(p, a);
      vy = coord_y(p, c) - coord_y(p, a);
      return ux * vy - uy * vx;
   endfunction

   function automatic longint span_sq(rpfp_pkg::point_set_type p, int a, int b);
      longint dx, dy;
      dx = coord_x(p, a) - coord_x(p, b);
      dy = coord_y(p, a) - coord_y(p, b);
      return dx * dx + dy * dy;
   endfunction

   // polar order about the pivot, nearer first, then lower index
   function automatic bit sorts_ahead(rpfp_pkg::point_set_type p, int pivot, int a, int b);
      longint o, da, db;
      o = turn(p, pivot, a, b);
      if (o > 0) return 1'b1;
      if (o < 0) return 1'b0;
      da = span_sq(p, pivot, a);
      db = span_sq(p, pivot, b);
      if (da != db) return da < db;
      return a < b;
   endfunction

   function automatic partition_type predict_partition(rpfp_pkg::point_set_type p);
      int            pivot, n, depth, k, j;
      int            order [3];
      int            hull_stack [4];
      partition_type res;
      pivot = 0;
      for (k = 1; k < 4; k++) begin
         if (coord_y(p, k) < coord_y(p, pivot) ||
             (coord_y(p, k) == coord_y(p, pivot) && coord_x(p, k) < coord_x(p, pivot)))
            pivot = k;
      end
      n = 0;
      for (k = 0; k < 4; k++) begin
         if (k != pivot) begin
            j = n;
            while (j > 0 && sorts_ahead(p, pivot, k, order[j-1])) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = k;
            n++;
         end
      end
      hull_stack[0] = pivot;
      depth = 1;
      for (k = 0; k < 3; k++) begin
         while (depth >= 2 &&
                turn(p, hull_stack[depth-2], hull_stack[depth-1], order[k]) <= 0)
            depth--;
         hull_stack[depth] = order[k];
         depth++;
      end
      res.mask = 4'b0000;
      if (depth == 4) begin
         // the diagonal away from the pivot
         res.mask[hull_stack[1]] = 1'b1;
         res.mask[hull_stack[3]] = 1'b1;
         res.hull = rpfp_pkg::HULL_FOUR;
      end else begin
         for (k = 0; k < depth; k++) res.mask[hull_stack[k]] = 1'b1;
         res.hull = (depth == 3) ? rpfp_pkg::HULL_THREE : rpfp_pkg::HULL_TWO;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic rpfp_pkg::point_set_type make_set(int x0, int y0, int x1, int y1,
                                                        int x2, int y2, int x3, int y3);
      rpfp_pkg::point_set_type p;
      p.x[0] = rpfp_pkg::coord_type'(x0);  p.y[0] = rpfp_pkg::coord_type'(y0);
      p.x[1] = rpfp_pkg::coord_type'(x1);  p.y[1] = rpfp_pkg::coord_type'(y1);
      p.x[2] = rpfp_pkg::coord_type'(x2);  p.y[2] = rpfp_pkg::coord_type'(y2);
      p.x[3] = rpfp_pkg::coord_type'(x3);  p.y[3] = rpfp_pkg::coord_type'(y3);
      return p;
   endfunction

   // mostly short idles, now and then a long one
   function automatic int pick_idle_length();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 6))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         5: return 32766;
         default: return 32767;
      endcase
   endfunction

   function automatic rpfp_pkg::point_set_type random_points();
      rpfp_pkg::point_set_type p;
      int                      kind, k, bx, by, dx, dy, t, shared, src;
      kind = $urandom_range(0, 99);
      for (k = 0; k < 4; k++) begin
         p.x[k] = rpfp_pkg::coord_type'($urandom);
         p.y[k] = rpfp_pkg::coord_type'($urandom);
      end
      if (kind < 30) begin
         // full-range coordinates as drawn
      end else if (kind < 50) begin
         // tiny grid: lots of ties, collinear triples and duplicates
         for (k = 0; k < 4; k++) begin
            p.x[k] = rpfp_pkg::coord_type'(int'($urandom_range(0, 8)) - 4);
            p.y[k] = rpfp_pkg::coord_type'(int'($urandom_range(0, 8)) - 4);
         end
      end else if (kind < 65) begin
         bx = int'($urandom_range(0, 2000)) - 1000;
         by = int'($urandom_range(0, 2000)) - 1000;
         dx = int'($urandom_range(0, 100)) - 50;
         dy = int'($urandom_range(0, 100)) - 50;
         for (k = 0; k < 4; k++) begin
            t = int'($urandom_range(0, 40)) - 20;
            p.x[k] = rpfp_pkg::coord_type'(bx + t * dx);
            p.y[k] = rpfp_pkg::coord_type'(by + t * dy);
         end
      end else if (kind < 75) begin
         shared = $urandom;
         for (k = 0; k < 4; k++) begin
            if ($urandom_range(0, 1)) p.x[k] = rpfp_pkg::coord_type'(shared);
            else p.y[k] = rpfp_pkg::coord_type'(shared);
         end
      end else if (kind < 85) begin
         src = $urandom_range(0, 3);
         for (k = 0; k < 4; k++) begin
            if (k != src && $urandom_range(0, 2) == 0) begin
               p.x[k] = p.x[src];
               p.y[k] = p.y[src];
            end
         end
      end else begin
         for (k = 0; k < 4; k++) begin
            p.x[k] = rpfp_pkg::coord_type'(pick_extreme());
            p.y[k] = rpfp_pkg::coord_type'(pick_extreme());
         end
      end
      return p;
   endfunction

   // ---------------------------------------------------------------- channel tasks

   task automatic send_points(input rpfp_pkg::point_set_type p);
      int gap;
      gap = (req_idle_on && $urandom_range(0, 99) < 30) ? pick_idle_length() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_point0_x <= p.x[0];
      req_point0_y <= p.y[0];
      req_point1_x <= p.x[1];
      req_point1_y <= p.y[1];
      req_point2_x <= p.x[2];
      req_point2_y <= p.y[2];
      req_point3_x <= p.x[3];
      req_point3_y <= p.y[3];
      do @(posedge clock); while (!req_ready);
      expected_partitions.push_back(predict_partition(p));
   endtask

   task automatic wait_all_results();
      while (expected_partitions.size() != 0) @(posedge clock);
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_valid <= 1'b0;
      wait_all_results();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic run_directed_shapes();
      rpfp_pkg::point_set_type shapes [$];
      shapes.push_back(make_set(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
      shapes.push_back(make_set(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768));
      shapes.push_back(make_set(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      shapes.push_back(make_set(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      shapes.push_back(make_set(0, 0, 0, 0, 0, 0, 0, 0));
      // triangle with an inner point
      shapes.push_back(make_set(0, 0, 10, 0, 0, 10, 2, 2));
      shapes.push_back(make_set(3, 3, -10, -10, 20, -10, 0, 20));
      // fourth point on an edge through the pivot, then on the far edge
      shapes.push_back(make_set(0, 0, 10, 0, 5, 0, 0, 10));
      shapes.push_back(make_set(0, 0, 10, 0, 0, 10, 5, 5));
      // all collinear
      shapes.push_back(make_set(0, 0, 3, 3, 1, 1, 2, 2));
      shapes.push_back(make_set(5, -7, 5, 9, 5, 0, 5, 100));
      shapes.push_back(make_set(-32768, 0, 32767, 0, 0, 0, 100, 0));
      // coincident copies of the pivot and of other points
      shapes.push_back(make_set(0, 0, 0, 0, 10, 0, 0, 10));
      shapes.push_back(make_set(0, 0, 10, 0, 10, 0, 0, 10));
      shapes.push_back(make_set(1, 1, 4, 4, 1, 1, 4, 4));
      shapes.push_back(make_set(7, 7, 7, 7, -3, 7, 7, 7));
      shapes.push_back(make_set(0, 10, 10, 10, 0, 0, 0, 0));
      // pivot picked on a tie in y
      shapes.push_back(make_set(5, 0, -5, 0, 0, 10, 2, 5));
      // widest products and near-collinear extremes
      shapes.push_back(make_set(-32768, -32768, 32767, -32767, -32767, 32767, 32767, 32767));
      shapes.push_back(make_set(-32768, -32768, 32767, 32767, 32766, 32767, 0, 1));
      shapes.push_back(make_set(-32768, 32767, 32767, -32768, -32767, 32766, 0, 0));
      shapes.push_back(make_set(10, 10, 0, 10, 0, 0, 10, 0));
      foreach (shapes[k]) send_points(shapes[k]);
   endtask

   task automatic run_random_mix(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         // change idling every hundred sets so some stretches run flat out
         if (k % 100 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         send_points(random_points());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic run_backpressure();
      int k;
      req_idle_on   = 1'b0;
      hold_off_left = 300;
      for (k = 0; k < 60; k++) send_points(random_points());
      req_idle_on = 1'b1;
   endtask

   task automatic run_drain_pause();
      int k;
      for (k = 0; k < 40; k++) send_points(random_points());
      pause_sender();
      for (k = 0; k < 40; k++) send_points(random_points());
   endtask

   task automatic run_back_to_back();
      int k;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (k = 0; k < 100; k++) send_points(random_points());
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- response side

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else if (!rsp_idle_on) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            stall_left = pick_idle_length() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      partition_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_partitions.size() == 0) begin
            $error("unexpected transaction: mask %b hull %0d",
                   rsp_first_set_mask, rsp_hull_count);
            failures++;
         end else begin
            want = expected_partitions.pop_front();
            if (rsp_first_set_mask !== want.mask) begin
               $error("first_set_mask: expected %b, actual %b",
                      want.mask, rsp_first_set_mask);
               failures++;
            end
            if (rsp_hull_count !== want.hull) begin
               $error("hull_count: expected %0d, actual %0d", want.hull, rsp_hull_count);
               failures++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      failures      = 0;
      hold_off_left = 0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_point0_x  = '0;
      req_point0_y  = '0;
      req_point1_x  = '0;
      req_point1_y  = '0;
      req_point2_x  = '0;
      req_point2_y  = '0;
      req_point3_x  = '0;
      req_point3_y  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed_shapes();
      run_random_mix(1400);
      run_backpressure();
      run_drain_pause();
      run_back_to_back();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_partitions.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/rpfp_pkg.sv
hw/rtl/rpfp_front.sv
hw/rtl/rpfp_queue.sv
hw/rtl/rpfp_back.sv
hw/rtl/radon_partition_four_points_top.sv
verif/tb.sv
